/* hw/rtl/rgb_to_hsv_convert_core_defines.svh */
// Assertion macros used by the checker file.
`ifndef RGB_TO_HSV_CONVERT_CORE_DEFINES_SVH
`define RGB_TO_HSV_CONVERT_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define RHC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhc assertion failed");

// Check that a condition implies another in the following cycle.
`define RHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhc assertion failed");

`endif

/* hw/rtl/rhc_pkg.sv */
package rhc_pkg;

  localparam int HUE_W          = 16;
  localparam int SAT_W          = 16;
  localparam int CH_W           = 8;
  localparam int DIV_STAGES     = 4;
  localparam int BITS_PER_STAGE = 4;
  localparam int HREM_W         = 12;
  localparam int HDEN_W         = 11;
  localparam int SREM_W         = 9;

  localparam logic [SAT_W-1:0] SAT_FULL = '1;

  typedef struct packed {
    logic [HREM_W-1:0] hrem;
    logic [HDEN_W-1:0] hden;
    logic [HUE_W-1:0]  hq;
    logic [SREM_W-1:0] srem;
    logic [CH_W-1:0]   sden;
    logic [SAT_W-1:0]  sq;
    logic              grey;
    logic              sat_full;
    logic [CH_W-1:0]   value;
  } rhc_div_t;

endpackage

/* hw/rtl/rhc_if.sv */
interface rhc_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface rhc_hsv_if;
  logic        valid;
  logic        ready;
  logic [15:0] hue;
  logic [15:0] saturation;
  logic [7:0]  value;

  modport source (output valid, hue, saturation, value, input ready);
  modport sink (input valid, hue, saturation, value, output ready);
endinterface

/* hw/rtl/rhc_div_stage.sv */
module rhc_div_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  rhc_pkg::rhc_div_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output rhc_pkg::rhc_div_t dn_data
);
  import rhc_pkg::*;

  logic              valid_r;
  rhc_div_t          data_r;
  rhc_div_t          data_nxt;
  logic [HREM_W-1:0] hr2;
  logic [SREM_W-1:0] sr2;
  logic              hbit;
  logic              sbit;

  // Shift in one quotient bit per step for hue and saturation.
  always_comb begin
    data_nxt = up_data;
    hr2      = '0;
    sr2      = '0;
    hbit     = 1'b0;
    sbit     = 1'b0;
    for (int i = 0; i < BITS_PER_STAGE; i++) begin
      hr2  = {data_nxt.hrem[HREM_W-2:0], 1'b0};
      sr2  = {data_nxt.srem[SREM_W-2:0], 1'b0};
      hbit = (hr2 >= {1'b0, data_nxt.hden});
      sbit = (sr2 >= {1'b0, data_nxt.sden});
      data_nxt.hrem = hbit ? (hr2 - {1'b0, data_nxt.hden}) : hr2;
      data_nxt.srem = sbit ? (sr2 - {1'b0, data_nxt.sden}) : sr2;
      data_nxt.hq   = {data_nxt.hq[HUE_W-2:0], hbit};
      data_nxt.sq   = {data_nxt.sq[SAT_W-2:0], sbit};
    end
  end

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* hw/rtl/rgb_to_hsv_convert_core.sv */
// RGB to HSV pixel converter.
// Pipeline: 1 prep stage, 4 divider stages, registered in that order.
// Throughput: one pixel per cycle unless stalled; each divider stage resolves 4
// quotient bits of hue and saturation, and a stall holds every full stage in place.
// Reset: synchronous active-low rst_n clears all stage valid bits.
module rgb_to_hsv_convert_core (
  input  logic clk,
  input  logic rst_n,
  rhc_pixel_if.sink in_if,
  rhc_hsv_if.source out_if
);
  import rhc_pkg::*;

  logic [CH_W-1:0]   mx;
  logic [CH_W-1:0]   mn;
  logic [CH_W-1:0]   dl;
  logic [HDEN_W-1:0] hden;
  logic [HREM_W-1:0] hnum;
  rhc_div_t          prep_nxt;
  rhc_div_t          prep_r;
  logic              prep_valid_r;

  rhc_div_t dv_data  [DIV_STAGES+1];
  logic     dv_valid [DIV_STAGES+1];
  logic     dv_ready [DIV_STAGES+1];

  always_comb begin
    mx = (in_if.red > in_if.green) ? in_if.red : in_if.green;
    mx = (mx > in_if.blue) ? mx : in_if.blue;
    mn = (in_if.red < in_if.green) ? in_if.red : in_if.green;
    mn = (mn < in_if.blue) ? mn : in_if.blue;
    dl = mx - mn;
    hden = {1'b0, dl, 2'b00} + {2'b00, dl, 1'b0};
    if (in_if.green == mx) begin
      hnum = {3'b000, dl, 1'b0} + {4'h0, in_if.blue} - {4'h0, in_if.red};
    end else if (in_if.blue == mx) begin
      hnum = {2'b00, dl, 2'b00} + {4'h0, in_if.red} - {4'h0, in_if.green};
    end else if (in_if.green >= in_if.blue) begin
      hnum = {4'h0, in_if.green - in_if.blue};
    end else begin
      hnum = {1'b0, hden} - {4'h0, in_if.blue - in_if.green};
    end
    prep_nxt.hrem     = hnum;
    prep_nxt.hden     = hden;
    prep_nxt.hq       = '0;
    prep_nxt.srem     = {1'b0, dl};
    prep_nxt.sden     = mx;
    prep_nxt.sq       = '0;
    prep_nxt.grey     = (dl == '0);
    prep_nxt.sat_full = (dl == mx);
    prep_nxt.value    = mx;
  end

  assign in_if.ready = !prep_valid_r || dv_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      prep_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      prep_r <= prep_nxt;
    end
  end

  assign dv_data[0]  = prep_r;
  assign dv_valid[0] = prep_valid_r;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    rhc_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv_valid[s]),
      .up_ready (dv_ready[s]),
      .up_data  (dv_data[s]),
      .dn_valid (dv_valid[s+1]),
      .dn_ready (dv_ready[s+1]),
      .dn_data  (dv_data[s+1])
    );
  end

  assign dv_ready[DIV_STAGES] = out_if.ready;
  assign out_if.valid         = dv_valid[DIV_STAGES];
  assign out_if.value         = dv_data[DIV_STAGES].value;
  assign out_if.hue           = dv_data[DIV_STAGES].grey ? '0 : dv_data[DIV_STAGES].hq;
  assign out_if.saturation    = dv_data[DIV_STAGES].grey     ? '0 :
                                dv_data[DIV_STAGES].sat_full ? SAT_FULL :
                                dv_data[DIV_STAGES].sq;

endmodule

/* hw/rtl/rhc_checker.sv */
`include "rgb_to_hsv_convert_core_defines.svh"

module rhc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_hue,
  input logic [15:0] out_saturation,
  input logic [7:0]  out_value
);

  logic        out_stall;
  logic [39:0] out_pkt;
  logic        out_black;
  logic        out_zero_hs;
  logic        out_grey;
  logic        out_shaded;

  assign out_stall   = out_valid && !out_ready;
  assign out_pkt     = {out_hue, out_saturation, out_value};
  assign out_black   = out_valid && (out_value == 8'd0);
  assign out_zero_hs = (out_hue == 16'd0) && (out_saturation == 16'd0);
  assign out_grey    = out_valid && (out_saturation == 16'd0);
  assign out_shaded  = out_valid && (out_saturation != 16'd0);

  `RHC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_pkt))
  `RHC_ASSERT_SAME(a_black_zero, clk, rst_n, out_black, out_zero_hs)
  `RHC_ASSERT_SAME(a_grey_no_hue, clk, rst_n, out_grey, out_hue == 16'd0)
  `RHC_ASSERT_SAME(a_sat_min, clk, rst_n, out_shaded, out_saturation >= 16'd257)

endmodule

bind rgb_to_hsv_convert_core rhc_checker u_rhc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_hue        (out_if.hue),
  .out_saturation (out_if.saturation),
  .out_value      (out_if.value)
);
